### rtl/dri_pkg.sv
// Package with field widths, mode codes and IEEE-754 double constants.
package dri_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned FuncW = 2;
  localparam int unsigned ExpW  = 11;

  typedef enum logic [FuncW-1:0] {
    FUNC_TRUNC = 2'd0,
    FUNC_FLOOR = 2'd1,
    FUNC_CEIL  = 2'd2,
    FUNC_ROUND = 2'd3
  } func_t;

  localparam logic [DataW-1:0] SignBit  = 64'h8000_0000_0000_0000;
  localparam logic [DataW-1:0] OneBits  = 64'h3FF0_0000_0000_0000;
  localparam logic [ExpW-1:0]  ExpAll1  = 11'h7FF;
  localparam logic [ExpW-1:0]  ExpBias  = 11'd1023;
  localparam logic [ExpW-1:0]  ExpHalf  = 11'd1022;
  localparam logic [ExpW-1:0]  ExpInt   = 11'd1075;

endpackage

### rtl/dri_core.sv
// Combinational rounding of one double to an integral value.
module dri_core (
  input  logic [1:0]  func,
  input  logic [63:0] value,
  output logic [63:0] result
);
  import dri_pkg::*;

  logic              sign;
  logic              mag_nz;
  logic [ExpW-1:0]   e;
  logic [5:0]        fb;
  logic [DataW-1:0]  unit;
  logic [DataW-1:0]  mask;
  logic [DataW-1:0]  frac;
  logic [DataW-1:0]  half;
  logic [DataW-1:0]  trunc_v;
  logic              up;

  assign sign    = value[63];
  assign mag_nz  = |value[62:0];
  assign e       = value[62:52];
  // Only 1 to 52 fraction bits matter here, so six bits of the distance suffice.
  assign fb      = 6'(ExpInt - e);
  assign unit    = 64'd1 << fb;
  assign mask    = unit - 64'd1;
  assign half    = unit >> 1;
  assign frac    = value & mask;
  assign trunc_v = value & ~mask;

  // Decide whether the truncated value steps up by one unit.
  always_comb begin
    case (func_t'(func))
      FUNC_FLOOR: up = sign && (frac != '0);
      FUNC_CEIL:  up = !sign && (frac != '0);
      FUNC_ROUND: up = (frac & half) != '0;
      default:    up = 1'b0;
    endcase
  end

  // Pick the result by magnitude class.
  always_comb begin
    if (e == ExpAll1 || e >= ExpInt) begin
      result = value;
    end else if (e < ExpBias) begin
      case (func_t'(func))
        FUNC_FLOOR: result = (sign && mag_nz) ? (SignBit | OneBits) : '0;
        FUNC_CEIL:  result = (!sign && mag_nz) ? OneBits : '0;
        FUNC_ROUND: begin
          if (e == ExpHalf) result = {sign, OneBits[62:0]};
          else result = (sign && mag_nz) ? SignBit : '0;
        end
        default:    result = '0;
      endcase
    end else begin
      result = up ? (trunc_v + unit) : trunc_v;
    end
  end

endmodule

### rtl/double_round_to_integral.sv
// Top level of the double round-to-integral unit.
// Path from start to done: the input register, then the result register.
// Throughput: one item per cycle; busy is always low.
// The rounding logic between the two registers is a single shift, mask and add.
// Reset (rst_n low, synchronous) clears the valid flags; payload is not reset.
// done pulses for one cycle with the result; the receiver cannot stall.
module double_round_to_integral (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_func,
  input  logic [63:0]               in_value,
  output logic                      done,
  output logic [63:0]               out_result
);
  import dri_pkg::*;

  logic        in_vld_r;
  logic [1:0]  func_r;
  logic [63:0] value_r;
  logic        out_vld_r;
  logic [63:0] result_r;
  logic [63:0] result_nxt;

  assign busy = 1'b0;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start;
      out_vld_r <= in_vld_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r   <= in_func;
    value_r  <= in_value;
    result_r <= result_nxt;
  end

  dri_core u_core (
    .func   (func_r),
    .value  (value_r),
    .result (result_nxt)
  );

  assign done       = out_vld_r;
  assign out_result = result_r;

endmodule

### rtl/dri_checker.sv
// Port-level checker for the round-to-integral unit, with its bind.
module dri_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_func,
  input logic [63:0] in_value,
  input logic        done,
  input logic [63:0] out_result
);
  import dri_pkg::*;

  // Every accepted item yields a result once it has passed the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 done) else $error("missing result");

  // No result without an item accepted ahead of it through the input and result registers.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(start, 2)) else $error("spurious result");

  // NaN and infinity pass through unchanged.
  a_special: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_value[62:52] == ExpAll1 |=> ##1 out_result == $past(in_value, 2))
    else $error("special value altered");

  // Truncate never sets the result above the operand magnitude.
  a_trunc_sign: assert property (@(posedge clk) disable iff (!rst_n)
    start && in_func == FUNC_TRUNC |=> ##1
      (out_result[62:0] <= $past(in_value[62:0], 2)))
    else $error("truncate grew magnitude");

endmodule

bind double_round_to_integral dri_checker u_dri_checker (.*);
